>>> design/wta_pkg.sv
// Shared types and constants for the walkable triangle adjacency block.
package wta_pkg;

  localparam int unsigned THR_W   = 16;
  localparam int unsigned WIDE_W  = 128;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned SHIFT_L = 30;

  typedef enum logic [2:0] {
    KIND_REJECT = 3'd0,
    KIND_STORED = 3'd1,
    KIND_NEIGHBOR = 3'd2,
    KIND_DUPLICATE = 3'd3,
    KIND_FULL = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    SL_IDLE,
    SL_PROD,
    SL_SUM,
    SL_M1,
    SL_M2,
    SL_M3,
    SL_DONE
  } slope_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_START,
    T_SLOPE,
    T_SCAN,
    T_FIN
  } top_state_t;

  typedef struct packed {
    logic done;
    logic pass;
  } slope_res_t;

endpackage

>>> design/walkable_triangle_adjacency.sv
// Top level: request sequencing, vertex store scan and result staging.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in       | in_valid / in_stall  | in_{first,second,third}_{x,y,z}
//   out      | out_valid / out_stall| out_kind, out_node_index, out_other_index,
//            |                      | out_more_dropped, out_last
//   cfg      | cfg_we               | cfg_wdata (slope threshold)
//
// One request at a time. The slope test holds the request while a bit-serial
// 128-bit shift-add unit steps through the bits of |cy|, |a|^2 and |b|^2 in turn.
// The store scan then reads one earlier node per cycle from the vertex RAM, unless
// an output stall holds it, and then finishes.
// Output stalls hold the scan only when a report must move to the output, and
// hold the final result until the output register is free.
// Reset clears the node count; the vertex RAM needs no clearing.
module walkable_triangle_adjacency #(
  parameter int unsigned MAX_NODES   = 1024,
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned MAX_REPORTS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wta_pkg::THR_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_first_x,
  input  logic signed [COORD_BITS-1:0]  in_first_y,
  input  logic signed [COORD_BITS-1:0]  in_first_z,
  input  logic signed [COORD_BITS-1:0]  in_second_x,
  input  logic signed [COORD_BITS-1:0]  in_second_y,
  input  logic signed [COORD_BITS-1:0]  in_second_z,
  input  logic signed [COORD_BITS-1:0]  in_third_x,
  input  logic signed [COORD_BITS-1:0]  in_third_y,
  input  logic signed [COORD_BITS-1:0]  in_third_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_kind,
  output logic [wta_pkg::IDX_W-1:0]     out_node_index,
  output logic [wta_pkg::IDX_W-1:0]     out_other_index,
  output logic                          out_more_dropped,
  output logic                          out_last
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned TW   = 9 * C;
  localparam int unsigned AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CNTW = $clog2(MAX_NODES + 1);
  localparam int unsigned RW   = $clog2(MAX_REPORTS + 1);
  localparam int unsigned XW   = AW + wta_pkg::IDX_W;

  wta_pkg::top_state_t state_r, state_nxt;

  logic [wta_pkg::THR_W-1:0] thr_r;
  logic [TW-1:0]             tri_r;
  logic [CNTW-1:0]           count_r;
  logic [AW-1:0]             node_r, e_r, ce_r;
  logic                      cv_r;
  logic [RW-1:0]             rep_r;
  logic                      dropped_r;

  wta_pkg::kind_t            pk_kind_r;
  logic [AW-1:0]             pk_node_r, pk_other_r;

  logic                      out_valid_r;
  wta_pkg::kind_t            o_kind_r;
  logic [AW-1:0]             o_node_r, o_other_r;
  logic                      o_drop_r, o_last_r;

  wta_pkg::slope_res_t       sres;
  logic [TW-1:0]             rdata;
  logic                      accept, out_free, mem_we, mem_re;
  logic [8:0]                eq;
  logic [3:0]                hits;
  logic                      is_match, report, adv, scan_end, full;
  logic [XW-1:0]             node_x, other_x;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (count_r >= CNTW'(MAX_NODES));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        eq[3*i+j] = (rdata[3*i*C +: 3*C] == tri_r[3*j*C +: 3*C]);
      end
    end
  end
  assign hits     = 4'($countones(eq));
  assign is_match = cv_r && (hits >= 4'd2);
  assign report   = is_match && (rep_r < RW'(MAX_REPORTS));
  assign adv      = !cv_r || !report || out_free;
  assign scan_end = !cv_r && (e_r == node_r);

  wta_slope #(.COORD_BITS(COORD_BITS)) u_slope (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == wta_pkg::T_START),
    .tri_in    (tri_r),
    .threshold (thr_r),
    .res       (sres)
  );

  wta_store #(.DEPTH(MAX_NODES), .AW(AW), .DW(TW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(count_r)),
    .wdata (tri_r),
    .re    (mem_re),
    .raddr (e_r),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wta_pkg::T_IDLE:  if (accept) state_nxt = wta_pkg::T_START;
      wta_pkg::T_START: state_nxt = wta_pkg::T_SLOPE;
      wta_pkg::T_SLOPE: begin
        if (sres.done) begin
          state_nxt = (sres.pass && !full) ? wta_pkg::T_SCAN : wta_pkg::T_FIN;
        end
      end
      wta_pkg::T_SCAN:  if (scan_end) state_nxt = wta_pkg::T_FIN;
      wta_pkg::T_FIN:   if (out_free) state_nxt = wta_pkg::T_IDLE;
      default:          state_nxt = wta_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != wta_pkg::T_IDLE);
    mem_we   = (state_r == wta_pkg::T_SLOPE) && sres.done && sres.pass && !full;
    mem_re   = (state_r == wta_pkg::T_SCAN) && adv && (e_r != node_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wta_pkg::T_IDLE;
      thr_r       <= wta_pkg::THR_W'(9830);
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cv_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (mem_we) begin
        count_r <= count_r + 1'b1;
      end
      if (state_r == wta_pkg::T_SCAN && adv) begin
        cv_r <= mem_re;
      end
      if ((state_r == wta_pkg::T_SCAN && cv_r && report && adv) ||
          (state_r == wta_pkg::T_FIN && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tri_r <= {in_third_z, in_third_y, in_third_x,
                in_second_z, in_second_y, in_second_x,
                in_first_z, in_first_y, in_first_x};
    end
    if (state_r == wta_pkg::T_SLOPE && sres.done) begin
      pk_other_r <= '0;
      rep_r      <= '0;
      dropped_r  <= 1'b0;
      e_r        <= '0;
      node_r     <= AW'(count_r);
      if (!sres.pass) begin
        pk_kind_r <= wta_pkg::KIND_REJECT;
        pk_node_r <= '0;
      end else if (full) begin
        pk_kind_r <= wta_pkg::KIND_FULL;
        pk_node_r <= '0;
      end else begin
        pk_kind_r <= wta_pkg::KIND_STORED;
        pk_node_r <= AW'(count_r);
      end
    end
    if (state_r == wta_pkg::T_SCAN && adv) begin
      if (mem_re) begin
        e_r  <= e_r + 1'b1;
        ce_r <= e_r;
      end
      if (is_match && !report) begin
        dropped_r <= 1'b1;
      end
      if (report) begin
        // older report leaves; it cannot be the final one
        o_kind_r   <= pk_kind_r;
        o_node_r   <= pk_node_r;
        o_other_r  <= pk_other_r;
        o_drop_r   <= 1'b0;
        o_last_r   <= 1'b0;
        pk_kind_r  <= (hits == 4'd2) ? wta_pkg::KIND_NEIGHBOR : wta_pkg::KIND_DUPLICATE;
        pk_other_r <= ce_r;
        rep_r      <= rep_r + 1'b1;
      end
    end
    if (state_r == wta_pkg::T_FIN && out_free) begin
      o_kind_r  <= pk_kind_r;
      o_node_r  <= pk_node_r;
      o_other_r <= pk_other_r;
      o_drop_r  <= dropped_r;
      o_last_r  <= 1'b1;
    end
  end

  assign node_x  = {{wta_pkg::IDX_W{1'b0}}, o_node_r};
  assign other_x = {{wta_pkg::IDX_W{1'b0}}, o_other_r};

  assign out_valid        = out_valid_r;
  assign out_kind         = o_kind_r;
  assign out_node_index   = node_x[wta_pkg::IDX_W-1:0];
  assign out_other_index  = other_x[wta_pkg::IDX_W-1:0];
  assign out_more_dropped = o_drop_r;
  assign out_last         = o_last_r;

`ifndef SYNTHESIS
  a_rep_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wta_pkg::T_SCAN) |-> (rep_r <= RW'(MAX_REPORTS)))
    else $error("report count above cap");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wta_pkg::T_SCAN) |-> (e_r <= node_r) && (CNTW'(node_r) < count_r))
    else $error("scan pointer beyond stored nodes");

  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wta_pkg::T_FIN && out_free) |=> (out_valid && out_last))
    else $error("final result not presented");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (count_r < CNTW'(MAX_NODES)))
    else $error("store written when full");
`endif

endmodule

>>> design/wta_store.sv
// Vertex store: one synchronous RAM, one write and one registered read port.
module wta_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 144
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/wta_slope.sv
// Root-free slope test: edge vectors, squared lengths, bit-serial wide products.
module wta_slope #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [9*COORD_BITS-1:0]            tri_in,
  input  logic [wta_pkg::THR_W-1:0]          threshold,
  output wta_pkg::slope_res_t                res
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned DW  = C + 1;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned CW  = SQW + 1;
  localparam int unsigned LW  = SQW + 2;
  localparam int unsigned MW  = LW;
  localparam int unsigned WW  = wta_pkg::WIDE_W;

  wta_pkg::slope_state_t state_r, state_nxt;

  logic signed [DW-1:0]  d_r [6];   // ax ay az bx by bz
  logic signed [SQW-1:0] sq_r [6];
  logic signed [SQW-1:0] c1_r, c2_r;
  logic [LW-1:0]         la_r, lb_r;
  logic [WW-1:0]         acc_r, ma_r, lhs_r;
  logic [MW-1:0]         mb_r;
  logic                  pass_r;

  logic signed [CW-1:0]  cyv;
  logic [CW-1:0]         cy_abs;
  logic [WW-1:0]         acc_add;
  logic                  mul_end;

  function automatic logic signed [DW-1:0] crd(input logic [9*C-1:0] t, input int idx);
    crd = DW'($signed(t[idx*C +: C]));
  endfunction

  assign cyv     = CW'(c1_r) - CW'(c2_r);
  assign cy_abs  = cyv[CW-1] ? CW'(-cyv) : CW'(cyv);
  assign acc_add = mb_r[0] ? acc_r + ma_r : acc_r;
  assign mul_end = (mb_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wta_pkg::SL_IDLE: if (start) state_nxt = wta_pkg::SL_PROD;
      wta_pkg::SL_PROD: state_nxt = wta_pkg::SL_SUM;
      wta_pkg::SL_SUM:  state_nxt = wta_pkg::SL_M1;
      wta_pkg::SL_M1:   if (mul_end) state_nxt = wta_pkg::SL_M2;
      wta_pkg::SL_M2:   if (mul_end) state_nxt = wta_pkg::SL_M3;
      wta_pkg::SL_M3:   if (mul_end) state_nxt = wta_pkg::SL_DONE;
      wta_pkg::SL_DONE: state_nxt = wta_pkg::SL_IDLE;
      default:          state_nxt = wta_pkg::SL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wta_pkg::SL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      wta_pkg::SL_IDLE: begin
        d_r[0] <= crd(tri_in, 0) - crd(tri_in, 3);
        d_r[1] <= crd(tri_in, 1) - crd(tri_in, 4);
        d_r[2] <= crd(tri_in, 2) - crd(tri_in, 5);
        d_r[3] <= crd(tri_in, 0) - crd(tri_in, 6);
        d_r[4] <= crd(tri_in, 1) - crd(tri_in, 7);
        d_r[5] <= crd(tri_in, 2) - crd(tri_in, 8);
      end
      wta_pkg::SL_PROD: begin
        for (int k = 0; k < 6; k++) begin
          sq_r[k] <= SQW'(d_r[k] * d_r[k]);
        end
        c1_r <= SQW'(d_r[2] * d_r[3]);
        c2_r <= SQW'(d_r[0] * d_r[5]);
      end
      wta_pkg::SL_SUM: begin
        la_r  <= LW'($unsigned(sq_r[0])) + LW'($unsigned(sq_r[1])) + LW'($unsigned(sq_r[2]));
        lb_r  <= LW'($unsigned(sq_r[3])) + LW'($unsigned(sq_r[4])) + LW'($unsigned(sq_r[5]));
        acc_r <= '0;
        ma_r  <= WW'(cy_abs);
        mb_r  <= MW'(cy_abs);
        lhs_r <= WW'(threshold * threshold);  // parked here until cy^2 is done
      end
      wta_pkg::SL_M1: begin
        if (mul_end) begin
          ma_r  <= lhs_r;
          lhs_r <= acc_r << wta_pkg::SHIFT_L;
          mb_r  <= la_r;
          acc_r <= '0;
        end else begin
          acc_r <= acc_add;
          ma_r  <= ma_r << 1;
          mb_r  <= mb_r >> 1;
        end
      end
      wta_pkg::SL_M2: begin
        if (mul_end) begin
          ma_r  <= acc_r;
          mb_r  <= lb_r;
          acc_r <= '0;
        end else begin
          acc_r <= acc_add;
          ma_r  <= ma_r << 1;
          mb_r  <= mb_r >> 1;
        end
      end
      wta_pkg::SL_M3: begin
        if (mul_end) begin
          pass_r <= (la_r != '0) && (lb_r != '0) && (lhs_r >= acc_r);
        end else begin
          acc_r <= acc_add;
          ma_r  <= ma_r << 1;
          mb_r  <= mb_r >> 1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.done = (state_r == wta_pkg::SL_DONE);
    res.pass = pass_r;
  end

endmodule

>>> tb/tb.sv
// Testbench for walkable_triangle_adjacency: predicted results checked against the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] x, y, z;
  } vtx_t;

  typedef struct packed {
    vtx_t v1, v2, v3;
  } tri_t;

  typedef struct packed {
    wta_pkg::kind_t kind;
    logic [9:0]  node;
    logic [9:0]  other;
    logic        dropped;
    logic        last;
  } report_t;

  localparam int NODE_CAP = 1024;
  localparam int REPORT_CAP = 15;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 0, in_stall;
  tri_t cur;
  logic out_valid, out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [9:0] out_node_index, out_other_index;
  logic out_more_dropped, out_last;

  walkable_triangle_adjacency dut (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall,
    .in_first_x(cur.v1.x), .in_first_y(cur.v1.y), .in_first_z(cur.v1.z),
    .in_second_x(cur.v2.x), .in_second_y(cur.v2.y), .in_second_z(cur.v2.z),
    .in_third_x(cur.v3.x), .in_third_y(cur.v3.y), .in_third_z(cur.v3.z),
    .out_valid, .out_stall, .out_kind, .out_node_index, .out_other_index,
    .out_more_dropped, .out_last
  );

  initial begin
    cur = '0;
    forever #6 clk = ~clk;
  end

  // predictor state
  tri_t    mesh[NODE_CAP];
  int      mesh_count = 0;
  logic [15:0] threshold = 16'd9830;
  report_t expected_reports[$];
  tri_t    pending_tris[$];
  int      errors = 0, accepted = 0, checked = 0;
  int      tx_idle = 13, rx_idle = 55;
  int      hold_rx = 0;
  bit      taken = 0;

  function automatic bit is_walkable(tri_t t);
    longint ax, ay, az, bx, by, bz, la, lb, cy;
    logic [127:0] lhs, rhs;
    ax = t.v1.x - t.v2.x; ay = t.v1.y - t.v2.y; az = t.v1.z - t.v2.z;
    bx = t.v1.x - t.v3.x; by = t.v1.y - t.v3.y; bz = t.v1.z - t.v3.z;
    la = ax*ax + ay*ay + az*az;
    lb = bx*bx + by*by + bz*bz;
    if (la == 0 || lb == 0) return 0;
    cy = az*bx - ax*bz;
    if (cy < 0) cy = -cy;
    lhs = (128'(cy) * 128'(cy)) << 30;
    rhs = 128'(threshold) * 128'(threshold) * 128'(la) * 128'(lb);
    return lhs >= rhs;
  endfunction

  task automatic predict_triangle(tri_t t);
    report_t r;
    vtx_t a[3], b[3];
    int shared, n;
    bit dropped;
    r = '0;
    if (!is_walkable(t)) begin
      r.kind = wta_pkg::KIND_REJECT; r.last = 1;
      expected_reports = {expected_reports, r};
      return;
    end
    if (mesh_count >= NODE_CAP) begin
      r.kind = wta_pkg::KIND_FULL; r.last = 1;
      expected_reports = {expected_reports, r};
      return;
    end
    mesh[mesh_count] = t;
    r.kind = wta_pkg::KIND_STORED; r.node = 10'(mesh_count);
    expected_reports = {expected_reports, r};
    n = 1; dropped = 0;
    b[0] = t.v1; b[1] = t.v2; b[2] = t.v3;
    for (int e = 0; e < mesh_count; e++) begin
      a[0] = mesh[e].v1; a[1] = mesh[e].v2; a[2] = mesh[e].v3;
      shared = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if (a[i] == b[j]) shared++;
      if (shared >= 2) begin
        if (n - 1 < REPORT_CAP) begin
          r.kind = (shared == 2) ? wta_pkg::KIND_NEIGHBOR : wta_pkg::KIND_DUPLICATE;
          r.other = 10'(e);
          expected_reports = {expected_reports, r};
          n++;
        end else begin
          dropped = 1;
        end
      end
    end
    r = expected_reports.pop_back();
    r.dropped = dropped; r.last = 1;
    expected_reports = {expected_reports, r};
    mesh_count++;
  endtask

  // driver: a request that is still waiting stays on the bus unchanged
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !taken) begin
        in_valid <= 1;
      end else if (pending_tris.size() > 0 && $urandom_range(99) >= tx_idle) begin
        cur <= pending_tris[0];
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
      taken = 0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_rx > 0) begin
        hold_rx--;
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle);
      end
    end
  end

  // monitor: input accepts feed the predictor, results are checked
  always @(posedge clk) begin
    report_t got, want;
    if (rst_n && in_valid && !in_stall) begin
      predict_triangle(cur);
      accepted++;
      void'(pending_tris.pop_front());
      taken = 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{wta_pkg::kind_t'(out_kind), out_node_index, out_other_index,
              out_more_dropped, out_last};
      checked++;
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $realtime, got);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (got.kind != want.kind)
          $display("%0t kind: expected %0d actual %0d", $realtime, want.kind, got.kind);
        if (got.node != want.node)
          $display("%0t node_index: expected %0d actual %0d", $realtime, want.node, got.node);
        if (got.other != want.other)
          $display("%0t other_index: expected %0d actual %0d", $realtime, want.other,
                   got.other);
        if (got.dropped != want.dropped)
          $display("%0t more_dropped: expected %0b actual %0b", $realtime, want.dropped,
                   got.dropped);
        if (got.last != want.last)
          $display("%0t last: expected %0b actual %0b", $realtime, want.last, got.last);
        if (got != want) errors++;
      end
    end
  end

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vtx_t rand_vertex();
    vtx_t v;
    v.x = rand_coord(); v.z = rand_coord();
    v.y = $urandom_range(1) ? rand_coord() : 16'($urandom_range(7));
    return v;
  endfunction

  // triangle from three given vertices
  function automatic tri_t mk(vtx_t a, vtx_t b, vtx_t c);
    tri_t t;
    t.v1 = a; t.v2 = b; t.v3 = c;
    return t;
  endfunction

  function automatic vtx_t pt(int x, int y, int z);
    vtx_t v;
    v.x = 16'(x); v.y = 16'(y); v.z = 16'(z);
    return v;
  endfunction

  task automatic drain();
    while (pending_tris.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    threshold = v;
  endtask

  vtx_t pool[$];

  function automatic vtx_t pick();
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  initial begin
    vtx_t p, q, r;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: extremes, reject, collinear, duplicates, repeated vertices
    pending_tris = {pending_tris, mk(pt(0,0,0), pt(0,0,0), pt(5,0,5))};
    pending_tris = {pending_tris, mk(pt(0,0,0), pt(10,0,0), pt(0,0,10))};
    pending_tris = {pending_tris, mk(pt(0,0,0), pt(10,0,0), pt(0,0,10))};
    pending_tris = {pending_tris, mk(pt(10,0,0), pt(0,0,0), pt(10,0,10))};
    pending_tris = {pending_tris, mk(pt(0,0,0), pt(0,100,0), pt(0,0,10))};
    pending_tris = {pending_tris, mk(pt(0,0,0), pt(1,0,0), pt(2,0,0))};
    pending_tris = {pending_tris, mk(pt(-32768,-32768,-32768), pt(32767,32767,-32768),
                                     pt(-32768,32767,32767))};
    pending_tris = {pending_tris, mk(pt(-32768,0,-32768), pt(32767,0,-32768),
                                     pt(-32768,0,32767))};
    pending_tris = {pending_tris, mk(pt(0,0,0), pt(10,0,0), pt(0,0,0))};
    pending_tris = {pending_tris, mk(pt(10,0,0), pt(0,0,10), pt(0,0,0))};
    drain();

    write_threshold(16'd0);
    pending_tris = {pending_tris, mk(pt(0,0,0), pt(1,0,0), pt(2,0,0))};
    pending_tris = {pending_tris, mk(pt(0,0,0), pt(0,9,0), pt(0,0,10))};
    drain();
    write_threshold(16'd32768);
    pending_tris = {pending_tris, mk(pt(0,0,0), pt(10,0,0), pt(0,0,10))};
    drain();
    write_threshold(16'd65535);
    pending_tris = {pending_tris, mk(pt(0,0,0), pt(10,0,0), pt(0,0,10))};
    drain();
    write_threshold(16'd9830);

    // random: shared vertex pool makes neighbours and duplicates common
    for (int i = 0; i < 40; i++) pool = {pool, rand_vertex()};
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin tx_idle = 55; rx_idle = 13; end
      if (ph == 2) begin tx_idle = 0; rx_idle = 0; end
      for (int i = 0; i < 85; i++) begin
        p = pick(); q = pick(); r = pick();
        if ($urandom_range(9) == 0) pending_tris = {pending_tris, mk(rand_vertex(),
                                                    rand_vertex(), rand_vertex())};
        else pending_tris = {pending_tris, mk(p, q, r)};
        if (ph == 0 && i == 30) hold_rx = 2000;
      end
      drain();
      if (ph == 0) write_threshold(16'($urandom_range(1, 32767)));
      if (ph == 1) write_threshold(16'd2000);
    end
    $display("covered %0d triangles, %0d results; %0d nodes stored, thresholds 0..max",
             accepted, checked, mesh_count);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> walkable_triangle_adjacency.f
design/wta_pkg.sv
design/wta_store.sv
design/wta_slope.sv
design/walkable_triangle_adjacency.sv
tb/tb.sv
